>>> hdl/ui_text_escape_parser_assert.svh
// assertion macros for the text escape parser checks
`ifndef UI_TEXT_ESCAPE_PARSER_ASSERT_SVH
`define UI_TEXT_ESCAPE_PARSER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define TEP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("escape parser check failed");

// condition holds in the cycle after the trigger
`define TEP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("escape parser check failed");

`endif

>>> hdl/tep_pkg.sv
// shared types, codes and name tables of the text escape parser
package tep_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int NAME_COUNT      = 18;

  // parser phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_COLOR  = 3'd1;
  localparam logic [2:0] PH_BACK   = 3'd2;
  localparam logic [2:0] PH_OUTL   = 3'd3;
  localparam logic [2:0] PH_CURS   = 3'd4;
  localparam logic [2:0] PH_WEIGHT = 3'd5;
  localparam logic [2:0] PH_NAME   = 3'd6;

  // command classes: phase codes start a phase, plus these two
  localparam logic [2:0] CMD_BAD   = 3'd0;
  localparam logic [2:0] CMD_RESET = 3'd7;

  // result kinds
  localparam logic [2:0] KIND_INVALID = 3'd0;
  localparam logic [2:0] KIND_RESET   = 3'd1;
  localparam logic [2:0] KIND_COLOR   = 3'd2;
  localparam logic [2:0] KIND_BACK    = 3'd3;
  localparam logic [2:0] KIND_OUTLINE = 3'd4;
  localparam logic [2:0] KIND_WEIGHT  = 3'd5;
  localparam logic [2:0] KIND_CURSOR  = 3'd6;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
    logic [3:0] hex;
    logic [2:0] cmd;
    logic       wt_ok;
    logic [1:0] wt;
  } item_t;

  // names right-justified, first letter in the highest used byte
  localparam logic [63:0] NAME_TEXT [NAME_COUNT] = '{
    64'("white"), 64'("black"), 64'("clear"), 64'("silver"), 64'("gray"),
    64'("red"), 64'("maroon"), 64'("yellow"), 64'("olive"), 64'("lime"),
    64'("green"), 64'("aqua"), 64'("teal"), 64'("blue"), 64'("navy"),
    64'("fuchsia"), 64'("purple"), 64'("orange")
  };

  localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
    4'd5, 4'd5, 4'd5, 4'd6, 4'd4, 4'd3, 4'd6, 4'd6, 4'd5,
    4'd4, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4, 4'd7, 4'd6, 4'd6
  };

  localparam logic [31:0] NAME_RGBA [NAME_COUNT] = '{
    32'hFFFFFFFF, 32'h000000FF, 32'h00000000, 32'hC0C0C0FF, 32'h808080FF,
    32'hFF0000FF, 32'h800000FF, 32'hFFFF00FF, 32'h808000FF, 32'h00FF00FF,
    32'h008000FF, 32'h00FFFFFF, 32'h008080FF, 32'h0000FFFF, 32'h000080FF,
    32'hFF00FFFF, 32'h800080FF, 32'hFF8000FF
  };

  // letter of a name at a position below its length
  function automatic logic [7:0] name_char(input int idx, input logic [2:0] pos);
    logic [3:0] sh;
    sh = NAME_LEN[idx] - 4'd1 - {1'b0, pos};
    return NAME_TEXT[idx][{sh[2:0], 3'b000} +: 8];
  endfunction

endpackage

>>> hdl/tep_front.sv
// front end: takes bytes and classifies them for the back end
module tep_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    ch,
  input  logic          at_end,
  input  logic          q_full,
  output logic          push,
  output tep_pkg::item_t item
);
  import tep_pkg::*;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    item        = '0;
    item.ch     = ch;
    item.at_end = at_end;

    // hex digit value, anything else counts as zero
    if (ch >= 8'h30 && ch <= 8'h39) begin
      item.hex = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      item.hex = 4'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      item.hex = 4'(ch - 8'h37);
    end else begin
      item.hex = 4'd0;
    end

    unique case (ch)
      8'h72:   item.cmd = CMD_RESET;  // r
      8'h23:   item.cmd = PH_COLOR;   // #
      8'h40:   item.cmd = PH_BACK;    // @
      8'h7C:   item.cmd = PH_OUTL;    // |
      8'h63:   item.cmd = PH_CURS;    // c
      8'h2E:   item.cmd = PH_WEIGHT;  // .
      8'h7E:   item.cmd = PH_NAME;    // ~
      default: item.cmd = CMD_BAD;
    endcase

    unique case (ch)
      8'h6C: begin item.wt_ok = 1'b1; item.wt = 2'd0; end  // l
      8'h6E: begin item.wt_ok = 1'b1; item.wt = 2'd1; end  // n
      8'h62: begin item.wt_ok = 1'b1; item.wt = 2'd2; end  // b
      8'h68: begin item.wt_ok = 1'b1; item.wt = 2'd3; end  // h
      default: begin item.wt_ok = 1'b0; item.wt = 2'd0; end
    endcase
  end

endmodule

>>> hdl/tep_queue.sv
// small first-word-fall-through queue between front and back
module tep_queue #(
  parameter int DEPTH = tep_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tep_pkg::item_t wr_item,
  input  logic           pop,
  output tep_pkg::item_t rd_item,
  output logic           full,
  output logic           nonempty
);
  import tep_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign rd_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/tep_back.sv
// back end: escape state machine and the result register
module tep_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_nonempty,
  input  tep_pkg::item_t q_item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     kind,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue,
  output logic [7:0]     alpha,
  output logic [7:0]     amount,
  output logic [3:0]     consumed
);
  import tep_pkg::*;

  logic [2:0]            phase, phase_next;
  logic [3:0]            digit_count, digit_count_next;
  logic [31:0]           hex_accum, hex_accum_next;
  logic [NAME_COUNT-1:0] name_cand, name_cand_next;
  logic [2:0]            name_pos, name_pos_next;

  logic                  emit;
  logic [2:0]            r_kind;
  logic [31:0]           r_rgba;
  logic [7:0]            r_amount;
  logic [3:0]            r_consumed;

  logic [NAME_COUNT-1:0] keep;
  logic [3:0]            pos_inc;
  logic                  name_done;
  logic [4:0]            done_idx;
  logic [3:0]            need;

  // the output register frees up as its item is taken
  assign pop = q_nonempty && (!out_valid || out_ready);

  always_comb begin
    phase_next       = phase;
    digit_count_next = digit_count;
    hex_accum_next   = hex_accum;
    name_cand_next   = name_cand;
    name_pos_next    = name_pos;
    emit             = 1'b0;
    r_kind           = KIND_INVALID;
    r_rgba           = '0;
    r_amount         = '0;
    r_consumed       = '0;
    keep             = '0;
    pos_inc          = {1'b0, name_pos} + 4'd1;
    name_done        = 1'b0;
    done_idx         = '0;
    need             = (phase == PH_COLOR || phase == PH_BACK) ? 4'd8 : 4'd2;

    for (int i = 0; i < NAME_COUNT; i++) begin
      keep[i] = name_cand[i] && ({1'b0, name_pos} < NAME_LEN[i]) &&
                (name_char(i, name_pos) == q_item.ch);
    end
    // walk down so the lowest table index wins
    for (int i = NAME_COUNT - 1; i >= 0; i--) begin
      if (keep[i] && NAME_LEN[i] == pos_inc) begin
        name_done = 1'b1;
        done_idx  = 5'(i);
      end
    end

    if (pop) begin
      unique case (phase) inside
        PH_COLOR, PH_BACK, PH_OUTL, PH_CURS: begin
          if (q_item.at_end) begin
            emit       = 1'b1;
            r_consumed = 4'd1;
          end else begin
            hex_accum_next   = {hex_accum[27:0], q_item.hex};
            digit_count_next = digit_count + 4'd1;
            if (digit_count_next >= need) begin
              emit = 1'b1;
              unique case (phase)
                PH_COLOR: begin
                  r_kind = KIND_COLOR; r_rgba = hex_accum_next; r_consumed = 4'd9;
                end
                PH_BACK: begin
                  r_kind = KIND_BACK; r_rgba = hex_accum_next; r_consumed = 4'd9;
                end
                PH_OUTL: begin
                  r_kind = KIND_OUTLINE; r_amount = hex_accum_next[7:0];
                  r_consumed = 4'd3;
                end
                default: begin
                  r_kind = KIND_CURSOR; r_amount = hex_accum_next[7:0];
                  r_consumed = 4'd3;
                end
              endcase
            end
          end
        end
        PH_WEIGHT: begin
          emit = 1'b1;
          if (q_item.at_end) begin
            r_consumed = 4'd1;
          end else if (q_item.wt_ok) begin
            r_kind     = KIND_WEIGHT;
            r_amount   = {6'd0, q_item.wt};
            r_consumed = 4'd2;
          end else begin
            r_consumed = 4'd2;
          end
        end
        PH_NAME: begin
          if (q_item.at_end) begin
            emit       = 1'b1;
            r_consumed = 4'd1;
          end else if (name_done) begin
            emit       = 1'b1;
            r_kind     = KIND_COLOR;
            r_rgba     = NAME_RGBA[done_idx];
            r_consumed = pos_inc + 4'd1;
          end else if (keep == '0 || pos_inc > 4'd7) begin
            // byte that killed the last candidate is not consumed
            emit       = 1'b1;
            r_consumed = 4'd1;
          end else begin
            name_cand_next = keep;
            name_pos_next  = pos_inc[2:0];
          end
        end
        default: begin
          // idle or a stray code: this byte is a command
          digit_count_next = '0;
          hex_accum_next   = '0;
          name_cand_next   = '1;
          name_pos_next    = '0;
          phase_next       = PH_IDLE;
          if (q_item.at_end) begin
            emit = 1'b1;
          end else begin
            unique case (q_item.cmd)
              CMD_RESET: begin
                emit = 1'b1; r_kind = KIND_RESET; r_consumed = 4'd1;
              end
              CMD_BAD: begin
                emit = 1'b1; r_consumed = 4'd1;
              end
              default: phase_next = q_item.cmd;
            endcase
          end
        end
      endcase

      if (emit) begin
        phase_next       = PH_IDLE;
        digit_count_next = '0;
        hex_accum_next   = '0;
        name_cand_next   = '1;
        name_pos_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      digit_count <= '0;
      hex_accum   <= '0;
      name_cand   <= '1;
      name_pos    <= '0;
      out_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      digit_count <= digit_count_next;
      hex_accum   <= hex_accum_next;
      name_cand   <= name_cand_next;
      name_pos    <= name_pos_next;
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      kind     <= r_kind;
      red      <= r_rgba[31:24];
      green    <= r_rgba[23:16];
      blue     <= r_rgba[15:8];
      alpha    <= r_rgba[7:0];
      amount   <= r_amount;
      consumed <= r_consumed;
    end
  end

endmodule

>>> hdl/ui_text_escape_parser.sv
// top level of the text styling escape parser
// Takes one escape byte per item (or an end marker) and returns one result per
// escape with its kind, colour channels, amount and consumed byte count. The
// block accepts one item per clock cycle unless the output stalls: each byte
// is classified on entry, waits in a short queue (QUEUE_DEPTH items), and the
// back-end state machine takes one queued item per cycle while its result
// register is free; out_valid is registered, set as the byte closing an
// escape leaves the queue. Output stalls back up into the queue and then to
// in_ready; after a result the parser is idle and the next byte is a command.
module ui_text_escape_parser #(
  parameter int QUEUE_DEPTH = tep_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       at_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] alpha,
  output logic [7:0] amount,
  output logic [3:0] consumed
);
  import tep_pkg::*;

  item_t front_item;
  item_t q_item;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_nonempty;

  tep_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ch       (ch),
    .at_end   (at_end),
    .q_full   (q_full),
    .push     (push),
    .item     (front_item)
  );

  tep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_item  (front_item),
    .pop      (pop),
    .rd_item  (q_item),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  tep_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_item     (q_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .amount     (amount),
    .consumed   (consumed)
  );

endmodule

>>> hdl/tep_checker.sv
// port-level checks of the escape parser and their binding
`include "ui_text_escape_parser_assert.svh"

module tep_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic [7:0] alpha,
  input logic [7:0] amount,
  input logic [3:0] consumed
);
  import tep_pkg::*;

  // a stalled result holds
  `TEP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(consumed) && $stable(red) && $stable(green) && $stable(blue) && $stable(alpha) && $stable(amount))

  // leaving reset: queue empty, nothing to show
  `TEP_ASSERT_NOW(a_reset_clean, $past(rst), in_ready && !out_valid)

  // hex colour or background is always nine bytes, named colour four to eight
  `TEP_ASSERT_NOW(a_color_len, out_valid && (kind == KIND_COLOR || kind == KIND_BACK), amount == 8'd0 && consumed >= 4'd4 && consumed <= 4'd9 && (kind == KIND_COLOR || consumed == 4'd9))

  // two-digit and weight results carry no colour and a fixed length
  `TEP_ASSERT_NOW(a_amount_len, out_valid && (kind == KIND_OUTLINE || kind == KIND_CURSOR || kind == KIND_WEIGHT), red == 8'd0 && alpha == 8'd0 && (kind == KIND_WEIGHT ? (consumed == 4'd2 && amount <= 8'd3) : consumed == 4'd3))

  // invalid results are empty and short
  `TEP_ASSERT_NOW(a_invalid_empty, out_valid && kind == KIND_INVALID, red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0 && amount == 8'd0 && consumed <= 4'd2)

endmodule

bind ui_text_escape_parser tep_checker u_checker (.*);

>>> tb/tb_top.sv
// self-checking testbench for the text styling escape parser
`timescale 1ns / 100ps

// command bytes and weight letters
localparam logic [7:0] CH_RESET   = "r";
localparam logic [7:0] CH_FG      = "#";
localparam logic [7:0] CH_NAMED   = "~";
localparam logic [7:0] CH_BG      = "@";
localparam logic [7:0] CH_OUTLINE = "|";
localparam logic [7:0] CH_WEIGHT  = ".";
localparam logic [7:0] CH_CURSOR  = "c";
localparam logic [7:0] WL_LIGHT   = "l";
localparam logic [7:0] WL_NORMAL  = "n";
localparam logic [7:0] WL_BOLD    = "b";
localparam logic [7:0] WL_HEAVY   = "h";

typedef struct packed {
  logic [2:0] kind;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] amount;
  logic [3:0] consumed;
} escape_result_t;

function automatic string swatch_name(int i);
  case (i)
    0: return "white";   1: return "black";   2: return "clear";
    3: return "silver";  4: return "gray";    5: return "red";
    6: return "maroon";  7: return "yellow";  8: return "olive";
    9: return "lime";    10: return "green";  11: return "aqua";
    12: return "teal";   13: return "blue";   14: return "navy";
    15: return "fuchsia"; 16: return "purple"; default: return "orange";
  endcase
endfunction

function automatic logic [31:0] swatch_rgba(int i);
  case (i)
    0: return 32'hFFFFFFFF;  1: return 32'h000000FF;  2: return 32'h00000000;
    3: return 32'hC0C0C0FF;  4: return 32'h808080FF;  5: return 32'hFF0000FF;
    6: return 32'h800000FF;  7: return 32'hFFFF00FF;  8: return 32'h808000FF;
    9: return 32'h00FF00FF;  10: return 32'h008000FF; 11: return 32'h00FFFFFF;
    12: return 32'h008080FF; 13: return 32'h0000FFFF; 14: return 32'h000080FF;
    15: return 32'hFF00FFFF; 16: return 32'h800080FF; default: return 32'hFF8000FF;
  endcase
endfunction

class escape_scoreboard;
  typedef enum logic [2:0] {
    S_IDLE, S_FG_HEX, S_BG_HEX, S_OUTLINE_HEX, S_CURSOR_HEX, S_WEIGHT, S_NAME
  } parse_state_t;

  parse_state_t   state;
  logic [3:0]     digits;
  logic [31:0]    accum;
  logic [17:0]    cands;
  logic [2:0]     name_pos;
  escape_result_t pending_results[$];
  int             errors;
  int             bytes_in;
  int             kind_seen[8];

  function new();
    go_idle();
    errors = 0;
    bytes_in = 0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
  endfunction

  function void go_idle();
    state = S_IDLE;
    digits = '0;
    accum = '0;
    cands = '1;
    name_pos = '0;
  endfunction

  function logic [3:0] hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    return 4'd0;
  endfunction

  function bit close_escape(output escape_result_t r, input logic [2:0] k,
                            input logic [31:0] rgba, input logic [7:0] amt,
                            input logic [3:0] used);
    r.kind = k;
    {r.red, r.green, r.blue, r.alpha} = rgba;
    r.amount = amt;
    r.consumed = used;
    go_idle();
    return 1'b1;
  endfunction

  // one byte through the parser, returns 1 when an escape completes
  function bit parse_byte(input logic [7:0] c, input logic e, output escape_result_t r);
    logic [17:0] keep;
    int          need;
    int          p;
    string       nm;
    logic [7:0]  letter;
    r = '0;
    case (state)
      S_FG_HEX, S_BG_HEX, S_OUTLINE_HEX, S_CURSOR_HEX: begin
        need = (state == S_FG_HEX || state == S_BG_HEX) ? 8 : 2;
        if (e) return close_escape(r, tep_pkg::KIND_INVALID, 0, 0, 1);
        accum = {accum[27:0], hex_digit(c)};
        digits = digits + 4'd1;
        if (digits < need) return 1'b0;
        case (state)
          S_FG_HEX: return close_escape(r, tep_pkg::KIND_COLOR, accum, 0, 9);
          S_BG_HEX: return close_escape(r, tep_pkg::KIND_BACK, accum, 0, 9);
          S_OUTLINE_HEX: return close_escape(r, tep_pkg::KIND_OUTLINE, 0, accum[7:0], 3);
          default: return close_escape(r, tep_pkg::KIND_CURSOR, 0, accum[7:0], 3);
        endcase
      end
      S_WEIGHT: begin
        if (e) return close_escape(r, tep_pkg::KIND_INVALID, 0, 0, 1);
        case (c)
          WL_LIGHT:  return close_escape(r, tep_pkg::KIND_WEIGHT, 0, 0, 2);
          WL_NORMAL: return close_escape(r, tep_pkg::KIND_WEIGHT, 0, 1, 2);
          WL_BOLD:   return close_escape(r, tep_pkg::KIND_WEIGHT, 0, 2, 2);
          WL_HEAVY:  return close_escape(r, tep_pkg::KIND_WEIGHT, 0, 3, 2);
          default:   return close_escape(r, tep_pkg::KIND_INVALID, 0, 0, 2);
        endcase
      end
      S_NAME: begin
        if (e) return close_escape(r, tep_pkg::KIND_INVALID, 0, 0, 1);
        keep = '0;
        p = name_pos;
        for (int i = 0; i < tep_pkg::NAME_COUNT; i++) begin
          nm = swatch_name(i);
          if (cands[i] && p < nm.len()) begin
            letter = nm[p];
            if (letter == c) keep[i] = 1'b1;
          end
        end
        p++;
        for (int i = 0; i < tep_pkg::NAME_COUNT; i++) begin
          nm = swatch_name(i);
          if (keep[i] && nm.len() == p)
            return close_escape(r, tep_pkg::KIND_COLOR, swatch_rgba(i), 0, 4'(1 + p));
        end
        // the byte that drops the last candidate is not consumed
        if (keep == '0 || p > 7) return close_escape(r, tep_pkg::KIND_INVALID, 0, 0, 1);
        cands = keep;
        name_pos = 3'(p);
        return 1'b0;
      end
      default: ;
    endcase
    go_idle();
    if (e) return close_escape(r, tep_pkg::KIND_INVALID, 0, 0, 0);
    case (c)
      CH_RESET:   return close_escape(r, tep_pkg::KIND_RESET, 0, 0, 1);
      CH_FG:      state = S_FG_HEX;
      CH_BG:      state = S_BG_HEX;
      CH_OUTLINE: state = S_OUTLINE_HEX;
      CH_CURSOR:  state = S_CURSOR_HEX;
      CH_WEIGHT:  state = S_WEIGHT;
      CH_NAMED:   state = S_NAME;
      default:    return close_escape(r, tep_pkg::KIND_INVALID, 0, 0, 1);
    endcase
    return 1'b0;
  endfunction

  function void note_input(logic [7:0] c, logic e);
    escape_result_t r;
    bytes_in++;
    if (parse_byte(c, e, r)) pending_results.push_back(r);
  endfunction

  function void report(string field, int want, int got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endfunction

  function void check_result(escape_result_t got);
    escape_result_t want;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual kind %0d consumed %0d",
               $time, got.kind, got.consumed);
      return;
    end
    want = pending_results.pop_front();
    kind_seen[got.kind]++;
    if (got.kind != want.kind) report("kind", want.kind, got.kind);
    if (got.red != want.red) report("red", want.red, got.red);
    if (got.green != want.green) report("green", want.green, got.green);
    if (got.blue != want.blue) report("blue", want.blue, got.blue);
    if (got.alpha != want.alpha) report("alpha", want.alpha, got.alpha);
    if (got.amount != want.amount) report("amount", want.amount, got.amount);
    if (got.consumed != want.consumed) report("consumed", want.consumed, got.consumed);
  endfunction

  function int outstanding();
    return pending_results.size();
  endfunction
endclass

module tb_top;
  localparam int RANDOM_ITEMS = 1550;
  localparam int STALL_LIMIT  = 3000;
  localparam int LONG_HOLD    = 300;

  typedef struct {
    logic [7:0] c;
    logic       e;
  } stim_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] ch = 8'h00;
  logic       at_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] kind;
  logic [7:0] red, green, blue, alpha, amount;
  logic [3:0] consumed;

  escape_scoreboard sb = new();
  stim_byte_t       stim_q[$];
  int               stall_cycles = 0;

  ui_text_escape_parser uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .ch(ch), .at_end(at_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .red(red), .green(green), .blue(blue), .alpha(alpha),
    .amount(amount), .consumed(consumed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(ch, at_end);
      if (out_valid && out_ready)
        sb.check_result('{kind, red, green, blue, alpha, amount, consumed});
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog, no item moved for %0d cycles", $time, stall_cycles);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  task automatic push(logic [7:0] c, logic e);
    stim_q.push_back('{c, e});
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push(s[i], 1'b0);
  endtask

  // mostly real hex digits in either case, now and then any byte
  task automatic push_hex(int n);
    string digs;
    digs = "0123456789abcdefABCDEF";
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) push(8'($urandom), 1'b0);
      else push(digs[$urandom_range(0, 21)], 1'b0);
    end
  endtask

  task automatic push_escape();
    string      nm;
    int         k;
    int         need;
    logic [7:0] cmd;
    nm = swatch_name($urandom_range(0, tep_pkg::NAME_COUNT - 1));
    case ($urandom_range(0, 19))
      0, 1: begin push(CH_FG, 1'b0); push_hex(8); end
      2, 3: begin push(CH_BG, 1'b0); push_hex(8); end
      4: begin push(CH_OUTLINE, 1'b0); push_hex(2); end
      5: begin push(CH_CURSOR, 1'b0); push_hex(2); end
      6: push(CH_RESET, 1'b0);
      7, 8: begin
        push(CH_WEIGHT, 1'b0);
        case ($urandom_range(0, 4))
          0: push(WL_LIGHT, 1'b0);
          1: push(WL_NORMAL, 1'b0);
          2: push(WL_BOLD, 1'b0);
          3: push(WL_HEAVY, 1'b0);
          default: push(8'($urandom), 1'b0);
        endcase
      end
      9, 10, 11: begin push(CH_NAMED, 1'b0); push_text(nm); end
      12: begin
        // named colour with one byte replaced
        push(CH_NAMED, 1'b0);
        k = $urandom_range(0, nm.len() - 1);
        for (int j = 0; j < nm.len(); j++)
          push((j == k) ? 8'($urandom) : nm[j], 1'b0);
      end
      13: begin
        push(CH_NAMED, 1'b0);
        k = $urandom_range(0, nm.len() - 1);
        for (int j = 0; j < k; j++) push(nm[j], 1'b0);
        push(8'($urandom), 1'b1);
      end
      14: begin
        case ($urandom_range(0, 3))
          0: cmd = CH_FG;
          1: cmd = CH_BG;
          2: cmd = CH_OUTLINE;
          default: cmd = CH_CURSOR;
        endcase
        need = (cmd == CH_FG || cmd == CH_BG) ? 8 : 2;
        push(cmd, 1'b0);
        push_hex($urandom_range(0, need - 1));
        push(8'($urandom), 1'b1);
      end
      15: begin push(CH_WEIGHT, 1'b0); push(8'($urandom), 1'b1); end
      16: push(8'($urandom), 1'b1);
      17: push(8'($urandom), 1'b0);
      default: begin
        k = $urandom_range(1, 6);
        for (int j = 0; j < k; j++) push(8'($urandom), ($urandom_range(0, 7) == 0));
      end
    endcase
  endtask

  task automatic build_stimulus();
    // extremes, each command and the short or unmatched cases
    push(8'hFF, 1'b1);
    push(8'h00, 1'b0);
    push(8'hFF, 1'b0);
    push_text("r");
    push_text("|fF");
    push_text("cA0");
    push_text(".h");
    push_text(".q");
    push_text(".");
    push(8'h00, 1'b1);
    push_text("~red");
    push_text("~q");
    push_text("#");
    push(8'hFF, 1'b1);
    push_text("@");
    push(8'h00, 1'b1);
    while (stim_q.size() < RANDOM_ITEMS) push_escape();
    push(CH_RESET, 1'b0);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(stim_byte_t b, int idx);
    int gap;
    gap = ((idx / 80) % 3 == 1) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    ch <= b.c;
    at_end <= b.e;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    int taken;
    int gap;
    taken = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (taken == 150) gap = LONG_HOLD;
      else if ((taken / 60) % 3 == 2) gap = 0;
      else gap = $urandom_range(0, 16);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    build_stimulus();
    @(negedge clk);
    foreach (stim_q[i]) send_byte(stim_q[i], i);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d bytes: reset %0d, colour %0d, background %0d, outline %0d",
             sb.bytes_in, sb.kind_seen[tep_pkg::KIND_RESET],
             sb.kind_seen[tep_pkg::KIND_COLOR], sb.kind_seen[tep_pkg::KIND_BACK],
             sb.kind_seen[tep_pkg::KIND_OUTLINE]);
    $display("weight %0d, cursor %0d, invalid %0d results, %0d mismatches",
             sb.kind_seen[tep_pkg::KIND_WEIGHT], sb.kind_seen[tep_pkg::KIND_CURSOR],
             sb.kind_seen[tep_pkg::KIND_INVALID], sb.errors);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
